FILE: hdl/tcr_pkg.sv
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared widths, constants and types of the tetrahedron circumsphere radius
// core and its square root pipeline.
// ----------------------------------------------------------------------------
package tcr_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 16;
    localparam int COORD_W         = 32;
    localparam int N_COORD         = 12;
    localparam int S_DATA_W        = COORD_W * N_COORD;

    // Datapath widths, sized for the worst case of 32-bit coordinates
    localparam int D_W     = COORD_W + 1;      // vertex difference
    localparam int R_W     = D_W + 1;          // matrix row entry
    localparam int NRM_W   = 2 * D_W + 1;      // squared norm, kept signed
    localparam int H_W     = NRM_W + 1;        // right-hand side entry
    localparam int XP_W    = 2 * R_W;          // one cross product term
    localparam int CR_W    = XP_W + 1;         // cofactor
    localparam int DET_W   = R_W + CR_W + 2;   // determinant
    localparam int N_W     = H_W + CR_W + 2;   // numerator of one component
    localparam int NUM_W   = N_W + 1;          // |n| + |det|
    localparam int DIV_W   = DET_W + 1;        // 2*|det|
    localparam int Q_BITS  = 58;               // quotient bits below the limit
    localparam int DSH_W   = DIV_W + Q_BITS;   // divisor at its top position
    localparam int U_W     = Q_BITS + 1;       // signed centre offset
    localparam int T_W     = U_W + 1;          // centre minus vertex
    localparam int SQ_W    = 2 * T_W;          // squared component
    localparam int SS_W    = SQ_W + 2;         // sum of three squares
    localparam int SHL     = (OUT_FRAC_BITS > COORD_FRAC_BITS) ?
                             2 * (OUT_FRAC_BITS - COORD_FRAC_BITS) : 0;
    localparam int SHR     = (COORD_FRAC_BITS > OUT_FRAC_BITS) ?
                             2 * (COORD_FRAC_BITS - OUT_FRAC_BITS) : 0;
    localparam int SC_W    = SS_W + SHL;       // scaled square distance
    localparam int ROOT_W  = 51;               // clamped distance
    localparam int SUM_W   = ROOT_W + 2;
    localparam int RADIUS_W = 48;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

    // Limb split of the wide products (signed upper limb, unsigned lower limb)
    localparam int LIMB_W  = 34;                   // lower limb of cofactor and rhs
    localparam int CRH_W   = CR_W - LIMB_W;        // upper cofactor limb
    localparam int HH_W    = H_W - LIMB_W;         // upper right-hand side limb
    localparam int PDH_W   = D_W + CRH_W;          // difference x upper cofactor
    localparam int PDL_W   = D_W + LIMB_W + 1;     // difference x lower cofactor
    localparam int PHH_W   = HH_W + CRH_W;         // upper x upper
    localparam int PHL_W   = HH_W + LIMB_W + 1;    // upper rhs x lower cofactor
    localparam int PLH_W   = LIMB_W + 1 + CRH_W;   // lower rhs x upper cofactor
    localparam int PLL_W   = 2 * LIMB_W;           // lower x lower
    localparam int SQ_LIMB = 30;                   // lower limb of an offset
    localparam int TH_W    = T_W - SQ_LIMB;        // upper offset limb
    localparam int QHH_W   = 2 * TH_W;             // upper limb squared
    localparam int QHL_W   = TH_W + SQ_LIMB + 1;   // upper x lower
    localparam int QLL_W   = 2 * SQ_LIMB;          // lower limb squared

    // Neighbor indexes for the cross products
    localparam int NXT  [3] = '{1, 2, 0};
    localparam int NNXT [3] = '{2, 0, 1};

    // Nine vertex differences (vertex 1..3 minus vertex 0, x/y/z)
    typedef logic [8:0][D_W-1:0] dvec_t;

    // Sideband through the divider
    typedef struct packed {
        logic       valid;
        logic       deg;
        logic       ovf;
        logic [2:0] neg;
        dvec_t      d;
    } div_side_t;

    // Flags after the divider
    typedef struct packed {
        logic valid;
        logic deg;
        logic ovf;
    } flag_t;

endpackage

FILE: hdl/tcr_sqrt.sv
// ----------------------------------------------------------------------------
// tcr_sqrt
// Pipelined integer square root, one result bit per stage, clamped to
// ROOT_W bits (all ones when the true root does not fit).
// ----------------------------------------------------------------------------
module tcr_sqrt (
    input  logic                       aclk,
    input  logic                       ce,
    input  logic [tcr_pkg::SC_W-1:0]   s_in,
    output logic [tcr_pkg::ROOT_W-1:0] root
);
    import tcr_pkg::*;

    logic [SC_W-1:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];

    // Load the radicand
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= s_in;
            root_reg[0] <= '0;
        end
    end

    // Try one bit per stage, most significant first
    for (genvar j = 1; j <= ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - j;
        logic [SC_W-1:0] trial;
        assign trial = (SC_W'(root_reg[j-1]) << (B + 1)) + (SC_W'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (rem_reg[j-1] >= trial) begin
                    rem_reg[j]  <= rem_reg[j-1] - trial;
                    root_reg[j] <= root_reg[j-1] | (ROOT_W'(1) << B);
                end else begin
                    rem_reg[j]  <= rem_reg[j-1];
                    root_reg[j] <= root_reg[j-1];
                end
            end
        end
    end

    assign root = root_reg[ROOT_W];

endmodule

FILE: hdl/tetra_circumsphere_radius_core.sv
// ----------------------------------------------------------------------------
// tetra_circumsphere_radius_core
// Circumsphere radius of a tetrahedron: solves the 3x3 centre system by
// Cramer's rule, divides with rounding, and averages the four distances.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                Handshake
//  s_       in   s_tdata: v0_x,v0_y,v0_z,...,v3_z       tvalid/tready
//  m_       out  m_tdata: radius; m_tuser: degenerate   tvalid/tready
//
//  One request enters per cycle while the output is not held; the pipeline
//  has 9 setup stages, 58 divider stages, 5 distance stages, 52 root stages
//  and 2 output stages. The restoring divider and the root pipelines set its depth.
//  Reset clears only the valid bits. A stalled output register freezes the
//  whole pipeline at once, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module tetra_circumsphere_radius_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // v0_x, v0_y, v0_z, v1_x, ..., v3_z, 32 bits each from bit 0 up
    input  logic [tcr_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // radius (unsigned Q32.16)
    output logic [tcr_pkg::RADIUS_W-1:0]     m_tdata,
    // degenerate
    output logic                             m_tuser
);
    import tcr_pkg::*;

    logic adv;

    // Advance everything unless the output is held
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage 1: vertex differences
    // ------------------------------------------------------------------
    logic  st_valid_reg [1:8];
    dvec_t d_reg        [1:8];
    dvec_t d_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                d_next[i*3+k] = D_W'($signed(s_tdata[((i+1)*3+k)*COORD_W +: COORD_W]))
                              - D_W'($signed(s_tdata[k*COORD_W +: COORD_W]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= 8; s++) st_valid_reg[s] <= 1'b0;
        end else if (adv) begin
            st_valid_reg[1] <= s_tvalid;
            for (int s = 2; s <= 8; s++) st_valid_reg[s] <= st_valid_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[1] <= d_next;
            for (int s = 2; s <= 8; s++) d_reg[s] <= d_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: matrix rows and squared norms
    // ------------------------------------------------------------------
    logic signed [R_W-1:0]   r_reg   [3][3];
    logic signed [NRM_W-1:0] nrm_reg [3];
    logic signed [R_W-1:0]   r_next  [3][3];
    logic signed [NRM_W-1:0] nrm_next[3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r_next[0][k] = R_W'($signed(d_reg[1][k]));
            r_next[1][k] = R_W'($signed(d_reg[1][3+k])) - R_W'($signed(d_reg[1][k]));
            r_next[2][k] = R_W'($signed(d_reg[1][6+k]));
        end
        for (int i = 0; i < 3; i++) begin
            nrm_next[i] = '0;
            for (int k = 0; k < 3; k++) begin
                nrm_next[i] = nrm_next[i] + NRM_W'($signed(d_reg[1][i*3+k]))
                                          * NRM_W'($signed(d_reg[1][i*3+k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg   <= r_next;
            nrm_reg <= nrm_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: right-hand side and cross product terms
    // ------------------------------------------------------------------
    logic signed [H_W-1:0]  h3_reg [3];
    logic signed [XP_W-1:0] xp_reg [3][3][2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            h3_reg[0] <= H_W'(nrm_reg[0]);
            h3_reg[1] <= H_W'(nrm_reg[1]) - H_W'(nrm_reg[0]);
            h3_reg[2] <= H_W'(nrm_reg[2]);
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    xp_reg[j][k][0] <= XP_W'(r_reg[NXT[j]][NXT[k]])
                                     * XP_W'(r_reg[NNXT[j]][NNXT[k]]);
                    xp_reg[j][k][1] <= XP_W'(r_reg[NXT[j]][NNXT[k]])
                                     * XP_W'(r_reg[NNXT[j]][NXT[k]]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: cofactors
    // ------------------------------------------------------------------
    logic signed [H_W-1:0]  h4_reg [3];
    logic signed [CR_W-1:0] cr_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            h4_reg <= h3_reg;
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    cr_reg[j][k] <= CR_W'(xp_reg[j][k][0]) - CR_W'(xp_reg[j][k][1]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: limb products for the determinant and numerators
    // ------------------------------------------------------------------
    logic signed [CRH_W-1:0] cr_hi   [3][3];
    logic signed [LIMB_W:0]  cr_lo   [3][3];
    logic signed [HH_W-1:0]  h_hi    [3];
    logic signed [LIMB_W:0]  h_lo    [3];
    logic signed [PDH_W-1:0] pdh_reg [3];
    logic signed [PDL_W-1:0] pdl_reg [3];
    logic signed [PHH_W-1:0] phh_reg [3][3];
    logic signed [PHL_W-1:0] phl_reg [3][3];
    logic signed [PLH_W-1:0] plh_reg [3][3];
    logic [PLL_W-1:0]        pll_reg [3][3];

    // Split into a signed upper limb and a zero-extended lower limb
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            h_hi[j] = h4_reg[j][H_W-1:LIMB_W];
            h_lo[j] = {1'b0, h4_reg[j][LIMB_W-1:0]};
            for (int k = 0; k < 3; k++) begin
                cr_hi[j][k] = cr_reg[j][k][CR_W-1:LIMB_W];
                cr_lo[j][k] = {1'b0, cr_reg[j][k][LIMB_W-1:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                pdh_reg[k] <= PDH_W'($signed(d_reg[4][k])) * PDH_W'(cr_hi[0][k]);
                pdl_reg[k] <= PDL_W'($signed(d_reg[4][k])) * PDL_W'(cr_lo[0][k]);
                for (int j = 0; j < 3; j++) begin
                    phh_reg[j][k] <= PHH_W'(h_hi[j]) * PHH_W'(cr_hi[j][k]);
                    phl_reg[j][k] <= PHL_W'(h_hi[j]) * PHL_W'(cr_lo[j][k]);
                    plh_reg[j][k] <= PLH_W'(h_lo[j]) * PLH_W'(cr_hi[j][k]);
                    pll_reg[j][k] <= PLL_W'(h4_reg[j][LIMB_W-1:0])
                                   * PLL_W'(cr_reg[j][k][LIMB_W-1:0]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: recombine the limb products
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] dt_reg [3];
    logic signed [N_W-1:0]   nt_reg [3][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                dt_reg[k] <= (DET_W'(pdh_reg[k]) << LIMB_W) + DET_W'(pdl_reg[k]);
                for (int j = 0; j < 3; j++) begin
                    nt_reg[j][k] <= (N_W'(phh_reg[j][k]) << (2 * LIMB_W))
                                  + ((N_W'(phl_reg[j][k]) + N_W'(plh_reg[j][k])) << LIMB_W)
                                  + N_W'($signed({1'b0, pll_reg[j][k]}));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: sums
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] det_reg;
    logic signed [N_W-1:0]   n_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg <= dt_reg[0] + dt_reg[1] + dt_reg[2];
            for (int k = 0; k < 3; k++) begin
                n_reg[k] <= nt_reg[0][k] + nt_reg[1][k] + nt_reg[2][k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: magnitudes and signs for the rounded division
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] num_reg [3];
    logic [DIV_W-1:0] d2_reg;
    logic [2:0]       neg_reg;
    logic             deg_reg;
    logic [DET_W-1:0] dabs;

    assign dabs = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            deg_reg <= (det_reg == '0);
            d2_reg  <= {dabs, 1'b0};
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= (n_reg[k][N_W-1] ? NUM_W'(-n_reg[k]) : NUM_W'(n_reg[k]))
                            + NUM_W'(dabs);
                neg_reg[k] <= n_reg[k][N_W-1] ^ det_reg[DET_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: load and range check, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  div_rem_reg  [Q_BITS+1][3];
    logic [Q_BITS-1:0] div_q_reg    [Q_BITS+1][3];
    logic [DIV_W-1:0]  div_dv_reg   [Q_BITS+1];
    div_side_t         div_side_reg [Q_BITS+1];
    logic [DSH_W-1:0]  div_top;
    logic              ovf_next;

    assign div_top  = DSH_W'(d2_reg) << Q_BITS;
    assign ovf_next = (DSH_W'(num_reg[0]) >= div_top) ||
                      (DSH_W'(num_reg[1]) >= div_top) ||
                      (DSH_W'(num_reg[2]) >= div_top);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_side_reg[0].valid <= 1'b0;
        end else if (adv) begin
            div_side_reg[0].valid <= st_valid_reg[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_side_reg[0].deg <= deg_reg;
            div_side_reg[0].ovf <= ovf_next;
            div_side_reg[0].neg <= neg_reg;
            div_side_reg[0].d   <= d_reg[8];
            div_dv_reg[0]       <= d2_reg;
            for (int k = 0; k < 3; k++) begin
                div_rem_reg[0][k] <= num_reg[k];
                div_q_reg[0][k]   <= '0;
            end
        end
    end

    for (genvar j = 1; j <= Q_BITS; j++) begin : g_div
        localparam int B = Q_BITS - j;
        logic [DSH_W-1:0] dsh;
        assign dsh = DSH_W'(div_dv_reg[j-1]) << B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_side_reg[j].valid <= 1'b0;
            end else if (adv) begin
                div_side_reg[j].valid <= div_side_reg[j-1].valid;
            end
        end

        // Subtract the shifted divisor where it fits
        always_ff @(posedge aclk) begin
            if (adv) begin
                div_side_reg[j].deg <= div_side_reg[j-1].deg;
                div_side_reg[j].ovf <= div_side_reg[j-1].ovf;
                div_side_reg[j].neg <= div_side_reg[j-1].neg;
                div_side_reg[j].d   <= div_side_reg[j-1].d;
                div_dv_reg[j]       <= div_dv_reg[j-1];
                for (int k = 0; k < 3; k++) begin
                    if (DSH_W'(div_rem_reg[j-1][k]) >= dsh) begin
                        div_rem_reg[j][k] <= NUM_W'(DSH_W'(div_rem_reg[j-1][k]) - dsh);
                        div_q_reg[j][k]   <= div_q_reg[j-1][k] | (Q_BITS'(1) << B);
                    end else begin
                        div_rem_reg[j][k] <= div_rem_reg[j-1][k];
                        div_q_reg[j][k]   <= div_q_reg[j-1][k];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Distance stages: signed centre, offsets, limb squares, squares, sums
    // ------------------------------------------------------------------
    logic signed [U_W-1:0]   u_reg [3];
    dvec_t                   pd_reg;
    logic signed [T_W-1:0]   t_reg [4][3];
    logic signed [TH_W-1:0]  t_hi [4][3];
    logic signed [QHH_W-1:0] qhh_reg [4][3];
    logic signed [QHL_W-1:0] qhl_reg [4][3];
    logic [QLL_W-1:0]        qll_reg [4][3];
    logic [SQ_W-1:0]         sq_reg [4][3];
    logic [SC_W-1:0]         s_reg [4];
    flag_t                   pf_reg [1:5];
    logic signed [U_W-1:0]   q_s   [3];
    logic [SS_W-1:0]         ss_next [4];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_s[k] = $signed({1'b0, div_q_reg[Q_BITS][k]});
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                t_hi[i][k] = t_reg[i][k][T_W-1:SQ_LIMB];
            end
            ss_next[i] = SS_W'(sq_reg[i][0]) + SS_W'(sq_reg[i][1]) + SS_W'(sq_reg[i][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= 5; s++) pf_reg[s].valid <= 1'b0;
        end else if (adv) begin
            pf_reg[1].valid <= div_side_reg[Q_BITS].valid;
            for (int s = 2; s <= 5; s++) pf_reg[s].valid <= pf_reg[s-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pf_reg[1].deg <= div_side_reg[Q_BITS].deg;
            pf_reg[1].ovf <= div_side_reg[Q_BITS].ovf;
            for (int s = 2; s <= 5; s++) begin
                pf_reg[s].deg <= pf_reg[s-1].deg;
                pf_reg[s].ovf <= pf_reg[s-1].ovf;
            end
            // apply the sign of the rounded quotient
            pd_reg <= div_side_reg[Q_BITS].d;
            for (int k = 0; k < 3; k++) begin
                u_reg[k] <= div_side_reg[Q_BITS].neg[k] ? -q_s[k] : q_s[k];
            end
            // centre minus each vertex, relative to vertex 0
            for (int k = 0; k < 3; k++) begin
                t_reg[0][k] <= T_W'(u_reg[k]);
                for (int i = 1; i < 4; i++) begin
                    t_reg[i][k] <= T_W'(u_reg[k]) - T_W'($signed(pd_reg[(i-1)*3+k]));
                end
            end
            // square each offset from a signed upper and an unsigned lower limb
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 3; k++) begin
                    qhh_reg[i][k] <= QHH_W'(t_hi[i][k]) * QHH_W'(t_hi[i][k]);
                    qhl_reg[i][k] <= QHL_W'(t_hi[i][k])
                                   * QHL_W'($signed({1'b0, t_reg[i][k][SQ_LIMB-1:0]}));
                    qll_reg[i][k] <= QLL_W'(t_reg[i][k][SQ_LIMB-1:0])
                                   * QLL_W'(t_reg[i][k][SQ_LIMB-1:0]);
                end
            end
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 3; k++) begin
                    sq_reg[i][k] <= (SQ_W'(qhh_reg[i][k]) << (2 * SQ_LIMB))
                                  + (SQ_W'(qhl_reg[i][k]) << (SQ_LIMB + 1))
                                  + SQ_W'($signed({1'b0, qll_reg[i][k]}));
                end
                s_reg[i] <= (SC_W'(ss_next[i]) << SHL) >> SHR;
            end
        end
    end

    // ------------------------------------------------------------------
    // Square roots and matching flag delay
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] root [4];
    flag_t             fl_reg [ROOT_W+1];

    for (genvar i = 0; i < 4; i++) begin : g_root
        tcr_sqrt u_sqrt (
            .aclk (aclk),
            .ce   (adv),
            .s_in (s_reg[i]),
            .root (root[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= ROOT_W; s++) fl_reg[s].valid <= 1'b0;
        end else if (adv) begin
            fl_reg[0].valid <= pf_reg[5].valid;
            for (int s = 1; s <= ROOT_W; s++) fl_reg[s].valid <= fl_reg[s-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fl_reg[0].deg <= pf_reg[5].deg;
            fl_reg[0].ovf <= pf_reg[5].ovf;
            for (int s = 1; s <= ROOT_W; s++) begin
                fl_reg[s].deg <= fl_reg[s-1].deg;
                fl_reg[s].ovf <= fl_reg[s-1].ovf;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum, round the mean, saturate, and force zero when degenerate
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]    sum_reg;
    flag_t               sum_fl_reg;
    logic [SUM_W-1:0]    mean;
    logic [RADIUS_W-1:0] radius_next;
    logic                m_valid_reg;
    logic [RADIUS_W-1:0] m_radius_reg;
    logic                m_deg_reg;

    assign mean = (sum_reg + SUM_W'(2)) >> 2;

    always_comb begin
        if (sum_fl_reg.deg) begin
            radius_next = '0;
        end else if (sum_fl_reg.ovf || (mean > SUM_W'(RADIUS_MAX))) begin
            radius_next = RADIUS_MAX;
        end else begin
            radius_next = RADIUS_W'(mean);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_fl_reg.valid <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else if (adv) begin
            sum_fl_reg.valid <= fl_reg[ROOT_W].valid;
            m_valid_reg      <= sum_fl_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_fl_reg.deg <= fl_reg[ROOT_W].deg;
            sum_fl_reg.ovf <= fl_reg[ROOT_W].ovf;
            sum_reg        <= SUM_W'(root[0]) + SUM_W'(root[1])
                            + SUM_W'(root[2]) + SUM_W'(root[3]);
            m_radius_reg   <= radius_next;
            m_deg_reg      <= sum_fl_reg.deg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_radius_reg;
    assign m_tuser  = m_deg_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("degenerate result with nonzero radius");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> st_valid_reg[1])
        else $error("accepted request missing from first stage");

    a_freeze_div: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(div_side_reg[Q_BITS/2]))
        else $error("divider moved during a stall");

    a_far_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && sum_fl_reg.valid && sum_fl_reg.ovf && !sum_fl_reg.deg
        |=> m_tvalid && (m_tdata == RADIUS_MAX))
        else $error("far centre did not saturate");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for tetra_circumsphere_radius_core. Tetrahedra go in
// through the s_ channel; each one is also solved exactly in wide integers
// (Cramer's rule, rounded centre, floor square roots, mean of four). Results
// from the m_ channel are checked in order against those predictions, under
// several sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
typedef logic signed [255:0] wide_t;

class radius_scoreboard;

    typedef struct {
        logic [tcr_pkg::RADIUS_W-1:0] radius;
        logic                         degenerate;
    } radius_t;

    radius_t pending[$];
    int      errors;

    function new();
        errors = 0;
    endfunction

    function void cross3(input wide_t a[3], input wide_t b[3], output wide_t c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function logic [63:0] floor_root(input logic [255:0] s);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int bit_i = 50; bit_i >= 0; bit_i--) begin
            t = r | (128'd1 << bit_i);
            if ({128'd0, t * t} <= s) r = t;
        end
        return r[63:0];
    endfunction

    // Solve the circumsphere and average the four vertex distances
    function radius_t solve_radius(input logic [tcr_pkg::S_DATA_W-1:0] pts);
        int          hi_row[3] = '{1, 2, 3};
        int          lo_row[3] = '{0, 1, 0};
        longint      d[4][3];
        longint      u[3];
        wide_t       rr[3][3], cr[3][3], h[3];
        wide_t       det, n, s, t, shi, slo, x, y;
        logic [255:0] mag_n, mag_det, q;
        logic [63:0] total, rad;
        radius_t     res;
        for (int k = 0; k < 3; k++) d[0][k] = 0;
        for (int i = 1; i < 4; i++)
            for (int k = 0; k < 3; k++)
                d[i][k] = longint'($signed(pts[(i*3+k)*32 +: 32]))
                        - longint'($signed(pts[k*32 +: 32]));
        for (int i = 0; i < 3; i++) begin
            shi = 0;
            slo = 0;
            for (int k = 0; k < 3; k++) begin
                x = d[hi_row[i]][k];
                y = d[lo_row[i]][k];
                rr[i][k] = x - y;
                shi = shi + x * x;
                slo = slo + y * y;
            end
            h[i] = shi - slo;
        end
        cross3(rr[1], rr[2], cr[0]);
        cross3(rr[2], rr[0], cr[1]);
        cross3(rr[0], rr[1], cr[2]);
        det = rr[0][0] * cr[0][0] + rr[0][1] * cr[0][1] + rr[0][2] * cr[0][2];
        res.radius = '0;
        res.degenerate = 1'b1;
        if (det == 0) return res;
        res.degenerate = 1'b0;
        mag_det = (det < 0) ? -det : det;
        // Round each centre component to the nearest raw unit, ties away
        for (int k = 0; k < 3; k++) begin
            n = h[0] * cr[0][k] + h[1] * cr[1][k] + h[2] * cr[2][k];
            mag_n = (n < 0) ? -n : n;
            q = (mag_n + mag_det) / (mag_det << 1);
            if (q >= (256'd1 << tcr_pkg::Q_BITS)) begin
                res.radius = tcr_pkg::RADIUS_MAX;
                return res;
            end
            u[k] = ((n < 0) != (det < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
        end
        total = 0;
        for (int i = 0; i < 4; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) begin
                t = u[k] - d[i][k];
                s = s + t * t;
            end
            s = (s << tcr_pkg::SHL) >> tcr_pkg::SHR;
            total = total + floor_root(s);
        end
        rad = (total + 64'd2) >> 2;
        res.radius = (rad > {16'd0, tcr_pkg::RADIUS_MAX}) ? tcr_pkg::RADIUS_MAX
                                                         : rad[47:0];
        return res;
    endfunction

    function void note_request(input logic [tcr_pkg::S_DATA_W-1:0] pts);
        pending.push_back(solve_radius(pts));
    endfunction

    function void check_result(input logic [47:0] radius, input logic degenerate);
        radius_t want;
        if (pending.size() == 0) begin
            $error("unexpected result: radius %0d degenerate %0d", radius, degenerate);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (radius !== want.radius) begin
            $error("radius: expected %0d, actual %0d", want.radius, radius);
            errors++;
        end
        if (degenerate !== want.degenerate) begin
            $error("degenerate: expected %0d, actual %0d", want.degenerate, degenerate);
            errors++;
        end
    endfunction

endclass

module tb_top;

    typedef enum int { SHAPE_ANY, SHAPE_LOCAL, SHAPE_FLAT, SHAPE_SLIVER } shape_e;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tcr_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tcr_pkg::RADIUS_W-1:0]  m_tdata;
    logic                          m_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    radius_scoreboard sb = new();

    tetra_circumsphere_radius_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    function automatic logic [tcr_pkg::S_DATA_W-1:0] pack_pts(input int c[12]);
        logic [tcr_pkg::S_DATA_W-1:0] pts;
        for (int j = 0; j < 12; j++) pts[j*32 +: 32] = c[j];
        return pts;
    endfunction

    // Build one random tetrahedron of the given shape
    function automatic logic [tcr_pkg::S_DATA_W-1:0] random_tetra(input shape_e shape);
        int c[12];
        int base[3];
        int span;
        for (int k = 0; k < 3; k++) base[k] = $urandom;
        span = $urandom_range(30, 1);
        for (int j = 0; j < 12; j++) begin
            if (shape == SHAPE_ANY) c[j] = $urandom;
            else c[j] = base[j % 3] + ($urandom & ((1 << span) - 1)) - (1 << (span - 1));
        end
        if (shape == SHAPE_FLAT || shape == SHAPE_SLIVER)
            for (int k = 0; k < 3; k++) c[9+k] = c[3+k] + c[6+k] - c[k];
        if (shape == SHAPE_SLIVER) c[11] = c[11] + ($urandom_range(1) ? 1 : -1);
        return pack_pts(c);
    endfunction

    // Offer one request, idling first at random, and wait for its acceptance
    task automatic send_tetra(input logic [tcr_pkg::S_DATA_W-1:0] pts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pts;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(pts);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int     pmin, pmax;
        shape_e shape;
        pmin = 32'h8000_0000;
        pmax = 32'h7fff_ffff;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: degenerate, unit, extremes, flat and far-centre cases
        send_tetra(pack_pts('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_tetra(pack_pts('{0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536}));
        send_tetra(pack_pts('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1}));
        send_tetra(pack_pts('{pmin, pmin, pmin, pmax, pmin, pmin,
                              pmin, pmax, pmin, pmin, pmin, pmax}));
        send_tetra(pack_pts('{pmax, pmax, pmax, pmin, pmax, pmax,
                              pmax, pmin, pmax, pmax, pmax, pmin}));
        send_tetra(pack_pts('{pmin, pmax, pmin, pmax, pmin, pmax,
                              pmax, pmax, pmin, pmin, pmin, pmax}));
        send_tetra(pack_pts('{5, 7, 0, 100, 3, 0, -40, 90, 0, 65, 93, 0}));
        send_tetra(pack_pts('{0, 0, 0, 10, 10, 10, 20, 20, 20, -7, -7, -7}));
        send_tetra(pack_pts('{1, 2, 3, 1, 2, 3, 4, 5, 6, 7, 8, 10}));
        send_tetra(pack_pts('{0, 0, 0, 1 << 30, 0, 0, 0, 1 << 30, 0,
                              1 << 30, 1 << 30, 1}));
        send_tetra(pack_pts('{pmin, pmin, 0, pmax, pmin, 0, pmin, pmax, 0, pmax, pmax, 1}));
        send_tetra(pack_pts('{-65536, -131072, -3, -1, -65536, -70000,
                              -200000, -1, -9, -30000, -40000, -500000}));
        send_tetra(pack_pts('{-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0}));

        // Hold off until every result has come back
        drain();

        // Random: idle patterns, each with a quiet stretch first
        for (int phase = 0; phase < 4; phase++) begin
            for (int j = 0; j < 112; j++) begin
                send_idle_pct  = (j < 20) ? 0 : (phase == 1) ? 84 : (phase == 3) ? 7 : 0;
                recv_stall_pct = (j < 20) ? 0 : (phase == 2) ? 84 : (phase == 3) ? 7 : 0;
                case ($urandom_range(9))
                    0, 1: shape = SHAPE_ANY;
                    2:    shape = SHAPE_FLAT;
                    3:    shape = SHAPE_SLIVER;
                    default: shape = SHAPE_LOCAL;
                endcase
                send_tetra(random_tetra(shape));
            end
        end

        drain();
        recv_stall_pct = 0;
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Give up after a generous fixed time
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
